// File: src/blrhs_pkg.sv
`timescale 1ns / 1ps
package blrhs_pkg;

   localparam int KNOWN_MAX_DEF = 8;
   localparam int DIM_MAX_DEF   = 4;
   localparam int ORDER_MAX_DEF = 4;

   localparam int COEF_SLOTS = 4;
   localparam int DATA_W     = 32;
   localparam int COL_W      = 16;
   localparam int PROD_W     = 64;
   localparam int RND_W      = 48;
   localparam int PAIR_W     = 49;
   localparam int ACC_W      = 52;
   localparam int REQ_DATA_W = 248;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CFG  = 2'd1;
   localparam logic [1:0] ST_BAD_LOAD = 2'd2;

   localparam logic [1:0] CSR_ORDER       = 2'd0;
   localparam logic [1:0] CSR_UNKNOWN     = 2'd1;
   localparam logic [1:0] CSR_LEFT_LAST   = 2'd2;
   localparam logic [1:0] CSR_RIGHT_COUNT = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   typedef struct packed {
      logic [2:0]  order;
      logic [15:0] unknown_count;
      logic [2:0]  left_last;
      logic [15:0] knk1;
   } cfg_type;

   typedef struct packed {
      logic        row_go;
      logic [15:0] first_col;
      logic [15:0] last_col;
      logic [1:0]  dim;
   } row_ctl_type;

   typedef struct packed {
      logic        we;
      logic        right;
      logic [15:0] pos;
      logic [1:0]  dim;
      logic [31:0] value;
   } store_wr_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } lane_en_type;

   typedef struct packed {
      logic s4;
      logic s5;
   } merge_en_type;

endpackage

// File: src/blrhs_lane.sv
`timescale 1ns / 1ps
module blrhs_lane
   import blrhs_pkg::*;
#(
   parameter int KNOWN_MAX = KNOWN_MAX_DEF,
   parameter int DIM_MAX   = DIM_MAX_DEF,
   parameter int ORDER_MAX = ORDER_MAX_DEF,
   parameter int LANE      = 0
) (
   input  logic                    clock,
   input  lane_en_type             en,
   input  cfg_type                 cfg,
   input  row_ctl_type             row,
   input  store_wr_type            wr,
   input  logic signed [DATA_W-1:0] coef,
   output logic signed [RND_W-1:0] rnd
);

   localparam int KD    = KNOWN_MAX * DIM_MAX;
   localparam int DEPTH = 2 * KD;
   localparam int AW    = $clog2(DEPTH);
   localparam int KPW   = (KNOWN_MAX > 1) ? $clog2(KNOWN_MAX) : 1;

   logic [DATA_W-1:0] mem [DEPTH];

   logic signed [17:0] col_s;
   logic signed [17:0] right_pos;
   logic               slot_ok;
   logic               first_ok;
   logic               left_hit;
   logic               right_hit;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;

   logic                     hit1_ff;
   logic signed [DATA_W-1:0] coef1_ff;
   logic [DATA_W-1:0]        rd1_ff;
   logic                     hit2_ff;
   logic signed [PROD_W-1:0] prod2_in;
   logic signed [PROD_W-1:0] prod2_ff;
   logic signed [PROD_W-1:0] rsum;
   logic signed [RND_W-1:0]  rnd3_in;
   logic signed [RND_W-1:0]  rnd3_ff;

   // column served by this band slot
   always_comb begin
      col_s     = signed'(18'(row.last_col) + 18'(LANE + 1) - 18'(cfg.order));
      right_pos = col_s - $signed(18'(cfg.knk1));
      slot_ok   = 3'(LANE) < cfg.order;
      first_ok  = col_s >= $signed(18'(row.first_col));
      left_hit  = row.row_go && slot_ok && first_ok
                  && (col_s <= $signed(18'(cfg.left_last)))
                  && (col_s < $signed(18'(KNOWN_MAX)));
      right_hit = row.row_go && slot_ok && first_ok
                  && (col_s >= $signed(18'(cfg.knk1)))
                  && (col_s + $signed(18'(ORDER_MAX - 1)) >= $signed(18'(row.last_col)))
                  && (col_s < $signed(18'(cfg.unknown_count)))
                  && (right_pos < $signed(18'(KNOWN_MAX)));
      if (left_hit) begin
         rd_addr = AW'(col_s[KPW-1:0]) * AW'(DIM_MAX) + AW'(row.dim);
      end else begin
         rd_addr = AW'(KD) + AW'(right_pos[KPW-1:0]) * AW'(DIM_MAX) + AW'(row.dim);
      end
      wr_addr = (wr.right ? AW'(KD) : AW'(0))
                + AW'(wr.pos[KPW-1:0]) * AW'(DIM_MAX) + AW'(wr.dim);
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_addr] <= wr.value;
      end
      if (en.s1) begin
         rd1_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      prod2_in = coef1_ff * $signed(rd1_ff);
      rsum     = prod2_ff + 64'sd32768;
      rnd3_in  = hit2_ff ? rsum[PROD_W-1:16] : '0;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         hit1_ff  <= left_hit || right_hit;
         coef1_ff <= coef;
      end
      if (en.s2) begin
         hit2_ff  <= hit1_ff;
         prod2_ff <= prod2_in;
      end
      if (en.s3) begin
         rnd3_ff <= rnd3_in;
      end
   end

   assign rnd = rnd3_ff;

endmodule

// File: src/blrhs_merge.sv
`timescale 1ns / 1ps
module blrhs_merge
   import blrhs_pkg::*;
#(
   parameter int LANES = ORDER_MAX_DEF
) (
   input  logic                     clock,
   input  merge_en_type             en,
   input  logic signed [RND_W-1:0]  lane_rnd [LANES],
   input  logic signed [DATA_W-1:0] rhs,
   input  logic                     kind,
   input  logic [1:0]               status_in,
   output logic [DATA_W-1:0]        adjusted,
   output logic [1:0]               status,
   output logic                     saturated
);

   localparam int NPAIR = (LANES + 1) / 2;

   logic signed [PAIR_W-1:0] pair_in [NPAIR];
   logic signed [PAIR_W-1:0] pair_ff [NPAIR];
   logic signed [DATA_W-1:0] rhs4_ff;
   logic                     kind4_ff;
   logic [1:0]               status4_ff;

   logic signed [ACC_W-1:0]  acc_in;
   logic                     sat_hi;
   logic                     sat_lo;
   logic [DATA_W-1:0]        adj_in;
   logic                     sat_in;
   logic [DATA_W-1:0]        adj_ff;
   logic [1:0]               status_ff;
   logic                     sat_ff;

   for (genvar k = 0; k < NPAIR; k++) begin : g_pair
      if (2 * k + 1 < LANES) begin : g_two
         assign pair_in[k] = PAIR_W'(lane_rnd[2*k]) + PAIR_W'(lane_rnd[2*k+1]);
      end else begin : g_one
         assign pair_in[k] = PAIR_W'(lane_rnd[2*k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         pair_ff    <= pair_in;
         rhs4_ff    <= rhs;
         kind4_ff   <= kind;
         status4_ff <= status_in;
      end
   end

   // subtract the band terms, then clip to Q16.16 range; load beats give zero
   always_comb begin
      acc_in = ACC_W'(rhs4_ff);
      for (int k = 0; k < NPAIR; k++) begin
         acc_in = acc_in - ACC_W'(pair_ff[k]);
      end
      sat_hi = acc_in > $signed(ACC_W'(32'h7FFF_FFFF));
      sat_lo = acc_in < $signed({{(ACC_W-DATA_W){1'b1}}, 32'h8000_0000});
      if (kind4_ff == KIND_LOAD) begin
         adj_in = '0;
         sat_in = 1'b0;
      end else if (sat_hi) begin
         adj_in = 32'h7FFF_FFFF;
         sat_in = 1'b1;
      end else if (sat_lo) begin
         adj_in = 32'h8000_0000;
         sat_in = 1'b1;
      end else begin
         adj_in = acc_in[DATA_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         adj_ff    <= adj_in;
         status_ff <= status4_ff;
         sat_ff    <= sat_in;
      end
   end

   assign adjusted  = adj_ff;
   assign status    = status_ff;
   assign saturated = sat_ff;

endmodule

// File: src/banded_lsq_boundary_rhs_adjust.sv
`timescale 1ns / 1ps
// Boundary right-hand-side adjustment for a banded least-squares system.
// req_* beats carry either a load (tuser = 0) that stores one known
// boundary coefficient component, or a row component (tuser = 1) whose
// rhs value gets the band dot product with the known columns subtracted.
// Every beat answers with exactly one rsp_* beat, in order: the adjusted
// Q16.16 value (zero for loads), a status code and a saturation flag.
// csr_* writes the four registers; csr_ready is high whenever reset is
// low. Write them only while no beat is in flight.
// An accepted beat passes five register stages before rsp_tvalid rises:
// store read at the accept edge, multiply, round, pair add, final add
// and clip. One lane per band slot, each with its own copy of the
// known-value store, so one beat is taken every cycle while rsp is not stalled.
// A stalled rsp side holds its beat; earlier stages keep filling until the
// pipeline is full, then req_tready drops.
// Reset clears the registers to their defaults and empties the pipeline;
// req_tready stays low while reset is high. Store contents are undefined
// until loaded.
module banded_lsq_boundary_rhs_adjust
   import blrhs_pkg::*;
#(
   parameter int KNOWN_MAX = KNOWN_MAX_DEF,
   parameter int DIM_MAX   = DIM_MAX_DEF,
   parameter int ORDER_MAX = ORDER_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_col, last_col, coef_0..coef_3, dim_index, rhs_value,
   // known_column, known_value, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // adjusted_value
   output logic [DATA_W-1:0]     rsp_tdata,
   // status, saturated
   output logic [2:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

   logic [2:0]  order_ff;
   logic [15:0] unknown_ff;
   logic [2:0]  left_last_ff;
   logic [3:0]  right_count_ff;

   logic [COL_W-1:0]         req_first;
   logic [COL_W-1:0]         req_last;
   logic signed [DATA_W-1:0] req_coef [COEF_SLOTS];
   logic [1:0]               req_dim;
   logic signed [DATA_W-1:0] req_rhs;
   logic [COL_W-1:0]         req_kcol;
   logic [DATA_W-1:0]        req_kval;

   cfg_type      cfg;
   row_ctl_type  row;
   store_wr_type wr;
   lane_en_type  lane_en;
   merge_en_type merge_en;

   logic        accept;
   logic        bad_cfg;
   logic        dim_ok;
   logic        left_sel;
   logic        right_sel;
   logic [15:0] load_pos;
   logic        load_ok;
   logic [1:0]  status_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   logic signed [DATA_W-1:0] rhs1_ff, rhs2_ff, rhs3_ff;
   logic                     kind1_ff, kind2_ff, kind3_ff;
   logic [1:0]               st1_ff, st2_ff, st3_ff;

   logic signed [RND_W-1:0] lane_rnd [ORDER_MAX];
   logic [DATA_W-1:0]       out_adj;
   logic [1:0]              out_status;
   logic                    out_sat;

   assign req_first   = req_tdata[15:0];
   assign req_last    = req_tdata[31:16];
   assign req_coef[0] = req_tdata[63:32];
   assign req_coef[1] = req_tdata[95:64];
   assign req_coef[2] = req_tdata[127:96];
   assign req_coef[3] = req_tdata[159:128];
   assign req_dim     = req_tdata[161:160];
   assign req_rhs     = req_tdata[193:162];
   assign req_kcol    = req_tdata[209:194];
   assign req_kval    = req_tdata[241:210];

   // configuration registers
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff       <= 3'd4;
         unknown_ff     <= 16'd16;
         left_last_ff   <= 3'd0;
         right_count_ff <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORDER:       order_ff       <= csr_data[2:0];
            CSR_UNKNOWN:     unknown_ff     <= csr_data;
            CSR_LEFT_LAST:   left_last_ff   <= csr_data[2:0];
            CSR_RIGHT_COUNT: right_count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.order         = order_ff;
      cfg.unknown_count = unknown_ff;
      cfg.left_last     = left_last_ff;
      cfg.knk1          = unknown_ff - 16'(right_count_ff);
      bad_cfg = (16'(left_last_ff) + 16'(right_count_ff)) >= unknown_ff;
   end

   // handshake and pipeline advance
   assign en5        = !v5_ff || rsp_tready;
   assign en4        = !v4_ff || en5;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1 && !reset;
   assign accept     = req_tvalid && req_tready;

   assign lane_en.s1  = en1;
   assign lane_en.s2  = en2;
   assign lane_en.s3  = en3;
   assign merge_en.s4 = en4;
   assign merge_en.s5 = en5;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // load decode (left range by column, right range offset from knk1), status and row control
   always_comb begin
      dim_ok    = 32'(req_dim) < 32'(DIM_MAX);
      left_sel  = req_kcol <= 16'(left_last_ff);
      right_sel = (req_kcol >= cfg.knk1) && (req_kcol < unknown_ff);
      load_pos  = left_sel ? req_kcol : req_kcol - cfg.knk1;
      load_ok   = (left_sel || right_sel) && (32'(load_pos) < 32'(KNOWN_MAX)) && dim_ok;

      if (bad_cfg) begin
         status_in = ST_BAD_CFG;
      end else if (req_tuser == KIND_LOAD && !load_ok) begin
         status_in = ST_BAD_LOAD;
      end else begin
         status_in = ST_OK;
      end

      wr.we    = accept && (req_tuser == KIND_LOAD) && !bad_cfg && load_ok;
      wr.right = !left_sel;
      wr.pos   = load_pos;
      wr.dim   = req_dim;
      wr.value = req_kval;

      row.row_go    = (req_tuser == KIND_ROW) && !bad_cfg && dim_ok;
      row.first_col = req_first;
      row.last_col  = req_last;
      row.dim       = req_dim;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         rhs1_ff  <= req_rhs;
         kind1_ff <= req_tuser;
         st1_ff   <= status_in;
      end
      if (en2) begin
         rhs2_ff  <= rhs1_ff;
         kind2_ff <= kind1_ff;
         st2_ff   <= st1_ff;
      end
      if (en3) begin
         rhs3_ff  <= rhs2_ff;
         kind3_ff <= kind2_ff;
         st3_ff   <= st2_ff;
      end
   end

   for (genvar g = 0; g < ORDER_MAX; g++) begin : g_lane
      blrhs_lane #(
         .KNOWN_MAX (KNOWN_MAX),
         .DIM_MAX   (DIM_MAX),
         .ORDER_MAX (ORDER_MAX),
         .LANE      (g)
      ) u_lane (
         .clock (clock),
         .en    (lane_en),
         .cfg   (cfg),
         .row   (row),
         .wr    (wr),
         .coef  (req_coef[g]),
         .rnd   (lane_rnd[g])
      );
   end

   blrhs_merge #(
      .LANES (ORDER_MAX)
   ) u_merge (
      .clock     (clock),
      .en        (merge_en),
      .lane_rnd  (lane_rnd),
      .rhs       (rhs3_ff),
      .kind      (kind3_ff),
      .status_in (st3_ff),
      .adjusted  (out_adj),
      .status    (out_status),
      .saturated (out_sat)
   );

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = out_adj;
   assign rsp_tuser  = {out_sat, out_status};

   a_bad_cfg_no_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] == ST_BAD_CFG) |-> !rsp_tuser[2])
      else $error("bad configuration beat flagged as saturated");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |->
         (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("saturated beat not at a range limit");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (req_tuser == KIND_LOAD && !bad_cfg && status_in == ST_OK))
      else $error("store written by a beat that must not write");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !v1_ff && !v4_ff))
      else $error("pipeline not empty after reset");

endmodule

// File: dv/tb_banded_lsq_boundary_rhs_adjust.sv
`timescale 1ns / 1ps
module tb_banded_lsq_boundary_rhs_adjust
   import blrhs_pkg::*;
();

   localparam int  HALF_PERIOD   = 4;
   localparam int  STALL_LIMIT   = 3000;
   localparam int  SETTLE_CYCLES = 8;
   localparam int  HOLD_CYCLES   = 200;
   localparam int  PHASES        = 10;
   localparam int  PHASE_ITEMS   = 170;
   localparam longint Q_MAX      = 64'sd2147483647;
   localparam longint Q_MIN      = -64'sd2147483648;

   // request beat fields, lowest bit at the bottom
   typedef struct packed {
      logic [5:0]  pad;
      logic [31:0] known_value;
      logic [15:0] known_column;
      logic [31:0] rhs_value;
      logic [1:0]  dim_index;
      logic [31:0] coef_3;
      logic [31:0] coef_2;
      logic [31:0] coef_1;
      logic [31:0] coef_0;
      logic [15:0] last_col;
      logic [15:0] first_col;
   } req_fields_t;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
      logic        saturated;
   } adj_result_t;

   class rhs_scoreboard;
      logic signed [31:0] left_store[KNOWN_MAX_DEF * DIM_MAX_DEF];
      logic signed [31:0] right_store[KNOWN_MAX_DEF * DIM_MAX_DEF];
      int order_reg;
      int unknown_reg;
      int left_last_reg;
      int right_count_reg;
      adj_result_t adjusted_q[$];
      int failures;

      function new();
         order_reg = 4;
         unknown_reg = 16;
         left_last_reg = 0;
         right_count_reg = 0;
         failures = 0;
         foreach (left_store[i]) begin
            left_store[i] = '0;
            right_store[i] = '0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_ORDER:       order_reg = int'(val[2:0]);
            CSR_UNKNOWN:     unknown_reg = int'(val);
            CSR_LEFT_LAST:   left_last_reg = int'(val[2:0]);
            CSR_RIGHT_COUNT: right_count_reg = int'(val[3:0]);
            default: ;
         endcase
      endfunction

      // one band product, rounded to Q16.16 with ties toward plus infinity
      function longint band_term(req_fields_t f, int col, logic signed [31:0] known);
         int slot;
         logic signed [31:0] c;
         longint p;
         slot = order_reg - 1 - (int'(f.last_col) - col);
         case (slot)
            0: c = f.coef_0;
            1: c = f.coef_1;
            2: c = f.coef_2;
            3: c = f.coef_3;
            default: c = '0;
         endcase
         p = longint'(c) * longint'(known);
         return (p + 64'sd32768) >>> 16;
      endfunction

      function void note_request(logic kind, req_fields_t f);
         adj_result_t r;
         int knk1, col, stop, start, pos, kcol, dim, last;
         longint acc;
         r = '0;
         knk1 = unknown_reg - right_count_reg;
         dim = int'(f.dim_index);
         kcol = int'(f.known_column);
         last = int'(f.last_col);
         if (left_last_reg + right_count_reg >= unknown_reg) begin
            r.status = ST_BAD_CFG;
            if (kind == KIND_ROW)
               r.value = f.rhs_value;
         end else if (kind == KIND_LOAD) begin
            if (kcol <= left_last_reg && kcol < KNOWN_MAX_DEF)
               left_store[kcol * DIM_MAX_DEF + dim] = f.known_value;
            else if (kcol >= knk1 && kcol < unknown_reg && kcol - knk1 < KNOWN_MAX_DEF)
               right_store[(kcol - knk1) * DIM_MAX_DEF + dim] = f.known_value;
            else
               r.status = ST_BAD_LOAD;
         end else begin
            acc = longint'($signed(f.rhs_value));
            stop = (last < left_last_reg) ? last : left_last_reg;
            for (col = int'(f.first_col); col <= stop; col++) begin
               if (col < KNOWN_MAX_DEF)
                  acc -= band_term(f, col, left_store[col * DIM_MAX_DEF + dim]);
            end
            start = (knk1 > int'(f.first_col)) ? knk1 : int'(f.first_col);
            if (start < last - (ORDER_MAX_DEF - 1))
               start = last - (ORDER_MAX_DEF - 1);
            stop = (last < unknown_reg - 1) ? last : unknown_reg - 1;
            for (col = start; col <= stop; col++) begin
               pos = col - knk1;
               if (pos >= 0 && pos < KNOWN_MAX_DEF)
                  acc -= band_term(f, col, right_store[pos * DIM_MAX_DEF + dim]);
            end
            if (acc > Q_MAX) begin
               r.value = 32'h7FFF_FFFF;
               r.saturated = 1'b1;
            end else if (acc < Q_MIN) begin
               r.value = 32'h8000_0000;
               r.saturated = 1'b1;
            end else begin
               r.value = acc[31:0];
            end
         end
         adjusted_q.push_back(r);
      endfunction

      function void check_response(logic [31:0] data, logic [2:0] user);
         adj_result_t r;
         if (adjusted_q.size() == 0) begin
            $error("rsp beat with nothing pending: adjusted_value %h", data);
            failures++;
            return;
         end
         r = adjusted_q.pop_front();
         if (data !== r.value) begin
            $error("adjusted_value: expected %h, actual %h", r.value, data);
            failures++;
         end
         if (user[1:0] !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, user[1:0]);
            failures++;
         end
         if (user[2] !== r.saturated) begin
            $error("saturated: expected %0d, actual %0d", r.saturated, user[2]);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [15:0]           csr_data = '0;

   rhs_scoreboard sb;
   bit gaps_on = 1'b1;
   bit hold_rsp = 1'b0;
   int stall_cycles = 0;

   int ph_order[PHASES] = '{4, 1, 2, 3, 4, 4, 2, 4, 3, 4};
   int ph_unk[PHASES]   = '{16, 9, 65535, 12, 1, 10, 8, 65535, 40, 24};
   int ph_left[PHASES]  = '{0, 7, 7, 2, 0, 3, 7, 0, 5, 7};
   int ph_right[PHASES] = '{0, 1, 8, 8, 0, 6, 1, 0, 3, 8};

   banded_lsq_boundary_rhs_adjust uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int clamp_col(int c);
      if (c < 0) return 0;
      if (c > 65535) return 65535;
      return c;
   endfunction

   function automatic req_fields_t row_item(int first, int last, logic [31:0] c0,
                                            logic [31:0] c1, logic [31:0] c2,
                                            logic [31:0] c3, logic [1:0] dim,
                                            logic [31:0] rhs);
      req_fields_t f;
      f.pad = '0;
      f.first_col = first[15:0];
      f.last_col = last[15:0];
      f.coef_0 = c0;
      f.coef_1 = c1;
      f.coef_2 = c2;
      f.coef_3 = c3;
      f.dim_index = dim;
      f.rhs_value = rhs;
      f.known_column = 16'($urandom);
      f.known_value = $urandom;
      return f;
   endfunction

   function automatic req_fields_t load_item(int col, logic [1:0] dim, logic [31:0] val);
      req_fields_t f;
      f = row_item(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                   $urandom, $urandom, $urandom, $urandom, dim, $urandom);
      f.known_column = col[15:0];
      f.known_value = val;
      return f;
   endfunction

   // keep tvalid high across back-to-back beats; drop it only for a gap
   task automatic send_beat(logic kind, req_fields_t f);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, f);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.adjusted_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(int order, int unk, int left_last, int right_count);
      logic [1:0]  regs[4] = '{CSR_ORDER, CSR_UNKNOWN, CSR_LEFT_LAST, CSR_RIGHT_COUNT};
      logic [15:0] vals[4];
      vals[0] = order[15:0];
      vals[1] = unk[15:0];
      vals[2] = left_last[15:0];
      vals[3] = right_count[15:0];
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_reg(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_beat();
      int knk1, lastc, firstc, col, sel;
      knk1 = sb.unknown_reg - sb.right_count_reg;
      if ($urandom_range(0, 99) < 15) begin
         sel = int'($urandom_range(0, 9));
         if (sel < 4 || (sel < 7 && sb.right_count_reg == 0))
            col = int'($urandom_range(0, sb.left_last_reg));
         else if (sel < 7)
            col = knk1 + int'($urandom_range(0, sb.right_count_reg - 1));
         else
            col = int'($urandom_range(0, 65535));
         send_beat(KIND_LOAD, load_item(clamp_col(col), 2'($urandom_range(0, 3)),
                                        rand_q16()));
      end else begin
         sel = int'($urandom_range(0, 9));
         if (sel < 4)
            lastc = int'($urandom_range(0, sb.left_last_reg + 4));
         else if (sel < 8)
            lastc = clamp_col(knk1 - 2 + int'($urandom_range(0, sb.right_count_reg + 5)));
         else
            lastc = int'($urandom_range(0, 65535));
         sel = int'($urandom_range(0, 9));
         if (sel < 7)
            firstc = clamp_col(lastc - (sb.order_reg - 1));
         else if (sel < 9)
            firstc = clamp_col(lastc - int'($urandom_range(0, 6)));
         else
            firstc = int'($urandom_range(0, 65535));
         send_beat(KIND_ROW, row_item(firstc, lastc, rand_q16(), rand_q16(), rand_q16(),
                                      rand_q16(), 2'($urandom_range(0, 3)), rand_q16()));
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every store entry so no row ever reads an unloaded word
      apply_config(4, 16, 7, 8);
      for (int col = 0; col < 16; col++)
         for (int d = 0; d < DIM_MAX_DEF; d++)
            send_beat(KIND_LOAD, load_item(col, 2'(d), rand_q16()));

      // left columns 0..3, right columns 16..19
      apply_config(4, 20, 3, 4);
      send_beat(KIND_LOAD, load_item(0, 2'd0, 32'h8000_0000));
      send_beat(KIND_LOAD, load_item(17, 2'd3, 32'h7FFF_FFFF));
      send_beat(KIND_LOAD, load_item(19, 2'd2, 32'h0001_0000));
      send_beat(KIND_LOAD, load_item(1, 2'd1, 32'h0000_0001));
      send_beat(KIND_LOAD, load_item(2, 2'd1, 32'hFFFF_FFFF));
      send_beat(KIND_LOAD, load_item(65535, 2'd0, 32'h1234_5678));
      send_beat(KIND_LOAD, load_item(10, 2'd3, 32'h1234_5678));
      send_beat(KIND_ROW, row_item(0, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 2'd0, 32'h7FFF_FFFF));
      send_beat(KIND_ROW, row_item(0, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 2'd0, 32'h8000_0000));
      // ties in the product rounding, both signs
      send_beat(KIND_ROW, row_item(0, 3, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                                   32'h0000_8000, 2'd1, 32'h0000_0000));
      send_beat(KIND_ROW, row_item(14, 17, $urandom, $urandom, $urandom, $urandom, 2'd3,
                                   $urandom));
      send_beat(KIND_ROW, row_item(5, 8, $urandom, $urandom, $urandom, $urandom, 2'd2,
                                   32'h1234_5678));
      send_beat(KIND_ROW, row_item(0, 65535, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                   32'h0001_0000, 2'd0, 32'h0000_0000));
      send_beat(KIND_ROW, row_item(17, 22, $urandom, $urandom, $urandom, $urandom, 2'd3,
                                   $urandom));
      send_beat(KIND_ROW, row_item(19, 19, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 2'd2,
                                   32'h0003_0000));
      send_beat(KIND_ROW, row_item(3, 0, $urandom, $urandom, $urandom, $urandom, 2'd0,
                                   $urandom));
      send_beat(KIND_ROW, row_item(0, 3, 32'h0, 32'h0, 32'h0, 32'h0, 2'd0, 32'h8000_0000));
      send_beat(KIND_ROW, row_item(16, 19, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h8000_0000, 2'd3, 32'h7FFF_FFFF));

      // left_last + right_count reaches unknown_count
      apply_config(4, 15, 7, 8);
      send_beat(KIND_ROW, row_item(0, 3, $urandom, $urandom, $urandom, $urandom, 2'd0,
                                   32'h8765_4321));
      send_beat(KIND_LOAD, load_item(0, 2'd0, 32'h1111_1111));

      for (int ph = 0; ph < PHASES; ph++) begin
         apply_config(ph_order[ph], ph_unk[ph], ph_left[ph], ph_right[ph]);
         if (ph == PHASES - 1)
            gaps_on = 1'b0;
         if (ph == 1)
            hold_rsp = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_beat();
      end

      drain();
      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
